### sv/scr_pkg.sv
// Shared constants and types for the SPI CAN controller register interface.
package scr_pkg;

    localparam int REG_COUNT = 128;
    localparam int ADDR_W    = $clog2(REG_COUNT);

    typedef logic [ADDR_W-1:0] addr_t;

    localparam logic [7:0] OP_WRITE  = 8'h02;
    localparam logic [7:0] OP_READ   = 8'h03;
    localparam logic [7:0] OP_BITMOD = 8'h05;
    localparam logic [7:0] OP_STATUS = 8'hA0;
    localparam logic [7:0] OP_RTS0   = 8'h81;
    localparam logic [7:0] OP_RESET  = 8'hC0;

    localparam addr_t ADDR_STAT   = ADDR_W'(8'h0E);
    localparam addr_t ADDR_CTRL   = ADDR_W'(8'h0F);
    localparam addr_t ADDR_INTF   = ADDR_W'(8'h2C);
    localparam addr_t ADDR_TXCTRL = ADDR_W'(8'h30);

    localparam logic [7:0] MODE_BITS   = 8'hE0;
    localparam logic [7:0] MODE_CONFIG = 8'h80;
    localparam logic [7:0] BIT_TXREQ   = 8'h08;
    localparam logic [7:0] BIT_TXERR   = 8'h10;
    localparam logic [7:0] BIT_TX0IF   = 8'h04;
    localparam logic [7:0] STATUS_MASK = 8'h03;

    typedef enum logic [1:0] {
        CMD_SPI_BYTE = 2'd0,
        CMD_CS_END   = 2'd1,
        CMD_TX_DONE  = 2'd2,
        CMD_TX_FAIL  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        PH_OPCODE  = 3'd0,
        PH_ADDR    = 3'd1,
        PH_DATA    = 3'd2,
        PH_MASK    = 3'd3,
        PH_MODDATA = 3'd4,
        PH_IGNORE  = 3'd5,
        PH_STATUS  = 3'd6
    } phase_t;

    typedef struct packed {
        logic       en;
        addr_t      addr;
        logic [7:0] data;
    } wr_req_t;

endpackage

### sv/scr_regfile.sv
// Register file memory with per-entry valid bits and a prefetched read port.
module scr_regfile
    import scr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  wr_req_t    wr,
    input  logic       clr,
    input  addr_t      rd_addr,
    output logic [7:0] rd_data
);

    logic [7:0]           mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [7:0]           rd_data_reg;
    logic                 rd_valid_reg;
    logic                 hit;

    assign hit = wr.en && (wr.addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= hit ? wr.data : mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= hit || valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : 8'h00;

endmodule

### sv/spi_can_controller_registers.sv
// Top level: SPI command decoder and register file of the CAN controller.
//
// Each input beat is one SPI byte (s_tuser = 0), a chip-select release (1),
// a bus transmit-done event (2) or a transmit-failed event (3); every beat
// yields exactly one result beat carrying the MISO byte and the current
// operating mode. A beat is taken every cycle unless an earlier result beat
// still waits on m_tready: the decoder, one register file access and the
// status/control registers are combinational between the input handshake
// and the output register, and the read port is prefetched at the next
// address pointer so data is ready when the next beat arrives. Register file
// contents clear at once on reset and on the reset instruction through
// per-entry valid bits, so no clearing pass is needed.
module spi_can_controller_registers
    import scr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] spi_byte
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] miso_byte, [10:8] op_mode, [15:11] zero
);

    phase_t     phase_reg, phase_next;
    logic [7:0] opcode_reg, opcode_next;
    addr_t      ptr_reg, ptr_next;
    logic [7:0] mask_reg, mask_next;
    logic [7:0] stat_reg, stat_next;
    logic [7:0] ctrl_reg, ctrl_next;
    logic [7:0] intf_reg, intf_next;
    logic [7:0] txctrl_reg, txctrl_next;
    logic       m_tvalid_reg;
    logic [15:0] m_tdata_reg;

    logic       accept;
    logic       spi_beat;
    cmd_t       cmd;
    wr_req_t    wr;
    logic       clr;
    logic [7:0] miso;
    logic [7:0] rf_rd_data;
    logic [7:0] cur_byte;
    logic [7:0] store_val;
    logic       store_en;
    addr_t      ptr_inc;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);
    assign spi_beat = accept && (cmd == CMD_SPI_BYTE);
    assign ptr_inc  = (ptr_reg == addr_t'(REG_COUNT - 1)) ? '0 : ptr_reg + addr_t'(1);

    always_comb begin
        unique case (ptr_reg)
            ADDR_STAT:   cur_byte = stat_reg;
            ADDR_CTRL:   cur_byte = ctrl_reg;
            ADDR_INTF:   cur_byte = intf_reg;
            ADDR_TXCTRL: cur_byte = txctrl_reg;
            default:     cur_byte = rf_rd_data;
        endcase
    end

    // phase sequencing
    always_comb begin
        phase_next = phase_reg;
        if (accept && cmd == CMD_CS_END) begin
            phase_next = PH_OPCODE;
        end else if (spi_beat) begin
            unique case (phase_reg)
                PH_OPCODE: begin
                    unique case (s_tdata) inside
                        OP_WRITE, OP_READ, OP_BITMOD: phase_next = PH_ADDR;
                        OP_STATUS:                    phase_next = PH_STATUS;
                        default:                      phase_next = PH_IGNORE;
                    endcase
                end
                PH_ADDR:    phase_next = (opcode_reg == OP_BITMOD) ? PH_MASK : PH_DATA;
                PH_MASK:    phase_next = PH_MODDATA;
                PH_MODDATA: phase_next = PH_IGNORE;
                default:    phase_next = phase_reg;
            endcase
        end
    end

    // datapath
    always_comb begin
        opcode_next = opcode_reg;
        ptr_next    = ptr_reg;
        mask_next   = mask_reg;
        stat_next   = stat_reg;
        ctrl_next   = ctrl_reg;
        intf_next   = intf_reg;
        txctrl_next = txctrl_reg;
        clr         = 1'b0;
        miso        = 8'h00;
        store_en    = 1'b0;
        store_val   = s_tdata;

        if (spi_beat) begin
            unique case (phase_reg)
                PH_OPCODE: begin
                    opcode_next = s_tdata;
                    if (s_tdata == OP_RESET) begin
                        clr         = 1'b1;
                        stat_next   = MODE_CONFIG;
                        ctrl_next   = MODE_CONFIG;
                        intf_next   = 8'h00;
                        txctrl_next = 8'h00;
                    end else if (s_tdata == OP_RTS0) begin
                        txctrl_next = txctrl_reg | BIT_TXREQ;
                    end
                end
                PH_ADDR: ptr_next = addr_t'(s_tdata % REG_COUNT);
                PH_DATA: begin
                    if (opcode_reg == OP_READ) begin
                        miso = cur_byte;
                    end else begin
                        store_en = 1'b1;
                    end
                    ptr_next = ptr_inc;
                end
                PH_MASK: mask_next = s_tdata;
                PH_MODDATA: begin
                    store_en  = 1'b1;
                    store_val = (cur_byte & ~mask_reg) | (s_tdata & mask_reg);
                end
                PH_STATUS: miso = intf_reg & STATUS_MASK;
                default: ;
            endcase
        end else if (accept && cmd == CMD_TX_DONE) begin
            txctrl_next = txctrl_reg & ~BIT_TXREQ;
            intf_next   = intf_reg | BIT_TX0IF;
        end else if (accept && cmd == CMD_TX_FAIL) begin
            txctrl_next = txctrl_reg | BIT_TXERR;
        end

        if (store_en) begin
            unique case (ptr_reg)
                ADDR_STAT: stat_next = store_val;
                ADDR_CTRL: begin
                    ctrl_next = store_val;
                    stat_next = (stat_reg & ~MODE_BITS) | (store_val & MODE_BITS);
                end
                ADDR_INTF:   intf_next   = store_val;
                ADDR_TXCTRL: txctrl_next = store_val;
                default: ;
            endcase
        end
    end

    assign wr.en   = store_en;
    assign wr.addr = ptr_reg;
    assign wr.data = store_val;

    scr_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .clr     (clr),
        .rd_addr (ptr_next),
        .rd_data (rf_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_OPCODE;
            opcode_reg   <= 8'h00;
            ptr_reg      <= '0;
            mask_reg     <= 8'h00;
            stat_reg     <= MODE_CONFIG;
            ctrl_reg     <= MODE_CONFIG;
            intf_reg     <= 8'h00;
            txctrl_reg   <= 8'h00;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            ptr_reg    <= ptr_next;
            mask_reg   <= mask_next;
            stat_reg   <= stat_next;
            ctrl_reg   <= ctrl_next;
            intf_reg   <= intf_next;
            txctrl_reg <= txctrl_next;
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {5'b0, stat_next[7:5], miso};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
